// ===== rtl/core/ltg_pkg.sv =====
// Shared constants, request codes and chain control type for the torus grid.
// Used by ltg_cell, ltg_chain and life_torus_generation.
package ltg_pkg;

    localparam int GRID_WIDTH  = 128;
    localparam int GRID_HEIGHT = 32;

    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT);
    // Per-column live count over one generation, 0 .. GRID_HEIGHT
    localparam int CNT_W = $clog2(GRID_HEIGHT + 1);

    localparam int POP_W = 13;
    localparam int GEN_W = 32;
    localparam logic [POP_W-1:0] POP_MAX = {POP_W{1'b1}};

    // Sequencer step counter must reach GRID_HEIGHT + 3 and GRID_WIDTH - 1
    localparam int STEP_MAX = (GRID_HEIGHT + 3 > GRID_WIDTH - 1) ?
                              (GRID_HEIGHT + 3) : (GRID_WIDTH - 1);
    localparam int STEP_W   = $clog2(STEP_MAX + 1);

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_LOW    = 4'd2;
    localparam logic [3:0] KEEP_HIGH   = 4'd3;

    typedef struct packed {
        logic shift;      // up <= mid <= dn <= incoming row bit
        logic load_first; // keep a copy of the old first row for the wrap
        logic use_first;  // feed the kept first row instead of memory data
        logic cnt_clear;
        logic cnt_add;    // count the new cell value of this row
        logic cnt_shift;  // move column counts one cell towards cell 0
    } ltg_ctl_t;

endpackage

// ===== rtl/core/ltg_cell.sv =====
// One column cell: holds three vertically adjacent bits of its column,
// applies the B3/S23 rule and keeps a running column population.
// Depends on ltg_pkg.
module ltg_cell
    import ltg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ltg_ctl_t         ctl,
    input  logic             rd_bit,
    input  logic [2:0]       left_col,
    input  logic [2:0]       right_col,
    input  logic [CNT_W-1:0] cnt_in,
    output logic [2:0]       own_col,
    output logic             new_bit,
    output logic [CNT_W-1:0] cnt_out
);

    logic             up_reg, mid_reg, dn_reg, first_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [3:0]       nbr_sum;

    assign own_col = {up_reg, mid_reg, dn_reg};
    assign cnt_out = cnt_reg;

    always_comb
    begin
        nbr_sum = 4'(left_col[2]) + 4'(left_col[1]) + 4'(left_col[0])
                + 4'(right_col[2]) + 4'(right_col[1]) + 4'(right_col[0])
                + 4'(up_reg) + 4'(dn_reg);
        if (mid_reg)
            new_bit = (nbr_sum == KEEP_LOW) || (nbr_sum == KEEP_HIGH);
        else
            new_bit = (nbr_sum == BIRTH_COUNT);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= dn_reg;
            dn_reg  <= ctl.use_first ? first_reg : rd_bit;
        end
        if (ctl.load_first)
            first_reg <= rd_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctl.cnt_clear)
            cnt_reg <= '0;
        else if (ctl.cnt_add)
            cnt_reg <= cnt_reg + CNT_W'(new_bit);
        else if (ctl.cnt_shift)
            cnt_reg <= cnt_in;
    end

endmodule

// ===== rtl/core/ltg_chain.sv =====
// Ring of column cells, one per grid column, wired with wrap-around
// neighbours; count values drain towards cell 0. Depends on ltg_pkg, ltg_cell.
module ltg_chain
    import ltg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ltg_ctl_t              ctl,
    input  logic [GRID_WIDTH-1:0] rd_row,
    output logic [GRID_WIDTH-1:0] new_row,
    output logic [CNT_W-1:0]      head_count
);

    logic [2:0]       col_w [GRID_WIDTH];
    logic [CNT_W-1:0] cnt_w [GRID_WIDTH];

    assign head_count = cnt_w[0];

    for (genvar i = 0; i < GRID_WIDTH; i++)
    begin : g_cell
        localparam int LEFT  = (i == 0) ? GRID_WIDTH - 1 : i - 1;
        localparam int RIGHT = (i == GRID_WIDTH - 1) ? 0 : i + 1;

        logic [CNT_W-1:0] cnt_in;

        if (i == GRID_WIDTH - 1)
        begin : g_tail
            assign cnt_in = '0;
        end
        else
        begin : g_body
            assign cnt_in = cnt_w[i + 1];
        end

        ltg_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .rd_bit    (rd_row[i]),
            .left_col  (col_w[LEFT]),
            .right_col (col_w[RIGHT]),
            .cnt_in    (cnt_in),
            .own_col   (col_w[i]),
            .new_bit   (new_row[i]),
            .cnt_out   (cnt_w[i])
        );
    end

endmodule

// ===== rtl/core/life_torus_generation.sv =====
// Game of Life (B3/S23) on a 128 x 32 torus with write, read and advance
// requests. Depends on ltg_pkg, ltg_chain.
//
// Input channel: in_valid / in_stall with req_type, cell_x, cell_y and
// cell_value; a transfer happens when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with cell_state, population and
// generation; exactly one result per request, in request order.
// The grid sits in a row-wide memory, one row per word. An advance streams
// the rows through a ring of GRID_WIDTH column cells, one row per cycle,
// then drains the column counts through cell 0 one column per cycle.
// A read or write goes through S_CELL to S_FIN; an unused code or an
// off-grid address goes straight to S_FIN; an advance passes S_ROWS
// and S_SUM before S_FIN. One request is in work at a time.
// After reset the block writes every row to dead, with in_stall held
// high; the counters start at zero.
// The result register is separate from the input side: a new request is
// taken while a result waits; if the receiver stalls, the next result is
// held inside until the register frees.
module life_torus_generation
    import ltg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       req_type,
    input  logic [6:0]       cell_x,
    input  logic [4:0]       cell_y,
    input  logic             cell_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             cell_state,
    output logic [POP_W-1:0] population,
    output logic [GEN_W-1:0] generation
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CELL  = 6'b000100,
        S_ROWS  = 6'b001000,
        S_SUM   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [POP_W-1:0]    pop_reg, pop_next;
    logic [GEN_W-1:0]    gen_reg, gen_next;
    logic                cs_reg, cs_next;

    logic [1:0]          req_reg;
    logic [6:0]          x_reg;
    logic [4:0]          y_reg;
    logic                v_reg;

    logic                out_valid_reg;
    logic                cell_state_reg;
    logic [POP_W-1:0]    population_reg;
    logic [GEN_W-1:0]    generation_reg;

    logic [GRID_WIDTH-1:0] grid_mem [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] rdata_reg;
    logic                  mem_re, mem_we;
    logic [ROW_W-1:0]      mem_ra, mem_wa;
    logic [GRID_WIDTH-1:0] mem_wd;

    ltg_ctl_t              ctl;
    logic [GRID_WIDTH-1:0] new_row;
    logic [CNT_W-1:0]      head_count;
    logic [GRID_WIDTH-1:0] row_mod;
    logic [COL_W-1:0]      col_idx;
    logic                  in_range;
    logic                  in_xfer;
    logic                  res_load;
    logic [POP_W:0]        pop_sum;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign res_load   = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign cell_state = cell_state_reg;
    assign population = population_reg;
    assign generation = generation_reg;

    assign in_range = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
    assign col_idx  = COL_W'(x_reg);
    assign pop_sum  = {1'b0, pop_reg} + (POP_W + 1)'(head_count);

    always_comb
    begin
        row_mod          = rdata_reg;
        row_mod[col_idx] = v_reg;
    end

    ltg_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .rd_row     (rdata_reg),
        .new_row    (new_row),
        .head_count (head_count)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rdata_reg <= grid_mem[mem_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pop_next   = pop_reg;
        gen_next   = gen_reg;
        cs_next    = cs_reg;
        mem_re     = 1'b0;
        mem_ra     = '0;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        ctl        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = ROW_W'(step_reg);
                if (step_reg == STEP_W'(GRID_HEIGHT - 1))
                begin
                    step_next  = '0;
                    state_next = S_IDLE;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cs_next = 1'b0;
                    if ((req_type == REQ_WRITE || req_type == REQ_READ) && in_range)
                    begin
                        mem_re     = 1'b1;
                        mem_ra     = ROW_W'(cell_y);
                        state_next = S_CELL;
                    end
                    else if (req_type == REQ_ADVANCE)
                    begin
                        step_next  = '0;
                        state_next = S_ROWS;
                    end
                    else
                        state_next = S_FIN;
                end
            end

            S_CELL:
            begin
                if (req_reg == REQ_WRITE)
                begin
                    mem_we  = 1'b1;
                    mem_wa  = ROW_W'(y_reg);
                    mem_wd  = row_mod;
                    cs_next = v_reg;
                end
                else
                    cs_next = rdata_reg[col_idx];
                state_next = S_FIN;
            end

            S_ROWS:
            begin
                // Read the last row first as the row above row 0, then rows
                // 0 to the last; the old row 0 is kept in the cells for the wrap.
                if (step_reg == '0)
                begin
                    mem_re = 1'b1;
                    mem_ra = ROW_W'(GRID_HEIGHT - 1);
                end
                else if (step_reg <= STEP_W'(GRID_HEIGHT))
                begin
                    mem_re = 1'b1;
                    mem_ra = ROW_W'(step_reg - STEP_W'(1));
                end

                ctl.shift      = (step_reg != '0);
                ctl.load_first = (step_reg == STEP_W'(2));
                ctl.use_first  = (step_reg == STEP_W'(GRID_HEIGHT + 2));
                ctl.cnt_clear  = (step_reg == '0);

                if (step_reg == '0)
                    pop_next = '0;

                // Write back one new row a cycle once three rows are held
                if (step_reg >= STEP_W'(4))
                begin
                    mem_we      = 1'b1;
                    mem_wa      = ROW_W'(step_reg - STEP_W'(4));
                    mem_wd      = new_row;
                    ctl.cnt_add = 1'b1;
                end

                if (step_reg == STEP_W'(GRID_HEIGHT + 3))
                begin
                    step_next  = '0;
                    state_next = S_SUM;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end

            S_SUM:
            begin
                ctl.cnt_shift = 1'b1;
                if (pop_sum > {1'b0, POP_MAX})
                    pop_next = POP_MAX;
                else
                    pop_next = pop_sum[POP_W-1:0];

                if (step_reg == STEP_W'(GRID_WIDTH - 1))
                begin
                    step_next  = '0;
                    gen_next   = gen_reg + GEN_W'(1);
                    state_next = S_FIN;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
            pop_reg   <= '0;
            gen_reg   <= '0;
            cs_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pop_reg   <= pop_next;
            gen_reg   <= gen_next;
            cs_reg    <= cs_next;
        end
    end

    // Hold the request fields for the whole of its work
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg <= req_type;
            x_reg   <= cell_x;
            y_reg   <= cell_y;
            v_reg   <= cell_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            cell_state_reg <= cs_reg;
            population_reg <= pop_reg;
            generation_reg <= gen_reg;
        end
    end

endmodule
